FILE: rtl/core/dcf_pkg.sv
// Shared types and constants for the delimited command framer.
package dcf_pkg;

   localparam int PAYLOAD_DEPTH = 10;
   localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1);
   localparam int IDX_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic       REG_START_BYTE = 1'b0;
   localparam logic       REG_END_BYTE   = 1'b1;
   localparam logic [7:0] START_RESET    = 8'h3C;
   localparam logic [7:0] END_RESET      = 8'h3E;

   localparam logic [7:0] CHAR_A = 8'h61;
   localparam logic [7:0] CHAR_B = 8'h62;
   localparam logic [7:0] CHAR_C = 8'h63;
   localparam logic [1:0] LED_A  = 2'd0;
   localparam logic [1:0] LED_B  = 2'd1;
   localparam logic [1:0] LED_C  = 2'd2;

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_EMIT  = 1'b1;

   // count holds the store index for CMD_STORE, the run length for CMD_EMIT
   typedef struct packed {
      logic             kind;
      logic [7:0]       data;
      logic [CNT_W-1:0] count;
   } cmd_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       byte_valid;
      logic       last;
      logic       command_ok;
      logic [1:0] led_index;
   } rsp_type;

endpackage

FILE: rtl/core/dcf_front.sv
// Front end: delimiter classification, frame tracking and command issue.
module dcf_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic            csr_index,
   input  logic [7:0]      csr_wdata,
   input  logic            in_accept,
   input  logic [7:0]      in_byte,
   output logic            cmd_push,
   output dcf_pkg::cmd_type cmd
);
   import dcf_pkg::*;

   logic [7:0]       start_byte_ff, start_byte_in;
   logic [7:0]       end_byte_ff, end_byte_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             open_ff, open_in;
   logic             has_room;

   assign has_room = fill_ff < CNT_W'(PAYLOAD_DEPTH);

   always_comb begin
      start_byte_in = start_byte_ff;
      end_byte_in   = end_byte_ff;
      if (csr_we) begin
         case (csr_index)
            REG_START_BYTE: start_byte_in = csr_wdata;
            REG_END_BYTE:   end_byte_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      fill_in   = fill_ff;
      open_in   = open_ff;
      cmd_push  = 1'b0;
      cmd.kind  = CMD_STORE;
      cmd.data  = in_byte;
      cmd.count = fill_ff;
      if (in_accept) begin
         if (in_byte == start_byte_ff) begin
            fill_in = '0;
            open_in = 1'b1;
         end else if (in_byte == end_byte_ff) begin
            if (open_ff) begin
               cmd_push = 1'b1;
               cmd.kind = CMD_EMIT;
               fill_in  = '0;
               open_in  = 1'b0;
            end
         end else if (has_room) begin
            cmd_push = 1'b1;
            fill_in  = fill_ff + 1'b1;
         end else begin
            open_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_RESET;
         end_byte_ff   <= END_RESET;
         fill_ff       <= '0;
         open_ff       <= 1'b0;
      end else begin
         start_byte_ff <= start_byte_in;
         end_byte_ff   <= end_byte_in;
         fill_ff       <= fill_in;
         open_ff       <= open_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(PAYLOAD_DEPTH))
      else $error("fill index beyond store depth");

   a_full_closes: assert property (@(posedge clock) disable iff (reset)
      in_accept && !has_room && in_byte != start_byte_ff && in_byte != end_byte_ff
      |=> !open_ff)
      else $error("overflow byte left frame open");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd_push && cmd.kind == CMD_EMIT |=> fill_ff == '0 && !open_ff)
      else $error("emit did not reset frame");

endmodule

FILE: rtl/core/dcf_cmd_queue.sv
// Short command queue between front end and back end.
module dcf_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dcf_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output dcf_pkg::cmd_type head
);
   import dcf_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full    = cnt_ff == (QPTR_W + 1)'(QUEUE_DEPTH);
   assign valid   = cnt_ff != '0;
   assign head    = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("command pushed into full queue");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPTR_W + 1)'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0 || full) |-> wr_ff == rd_ff)
      else $error("queue pointers out of step");

endmodule

FILE: rtl/core/dcf_back.sv
// Back end: payload store, command decode and run emission.
module dcf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  dcf_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   output dcf_pkg::rsp_type rsp,
   input  logic             rsp_pop
);
   import dcf_pkg::*;

   logic [7:0]       store_ff [PAYLOAD_DEPTH];
   logic             ok_ff, ok_in;
   logic [1:0]       led_ff, led_in;
   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             out_load;
   logic             run_end;
   logic             store_we;
   logic [IDX_W-1:0] store_idx;

   assign cmd_pop   = !busy_ff && cmd_valid;
   assign out_load  = busy_ff && (!rsp_valid_ff || rsp_pop);
   assign run_end   = (len_ff == '0) || (CNT_W'(pos_ff) + 1'b1 == len_ff);
   assign store_we  = cmd_pop && cmd.kind == CMD_STORE;
   assign store_idx = cmd.count[IDX_W-1:0];

   always_comb begin
      ok_in  = ok_ff;
      led_in = led_ff;
      if (store_we && cmd.count == '0) begin
         case (cmd.data)
            CHAR_A: begin ok_in = 1'b1; led_in = LED_A; end
            CHAR_B: begin ok_in = 1'b1; led_in = LED_B; end
            CHAR_C: begin ok_in = 1'b1; led_in = LED_C; end
            default: begin ok_in = 1'b0; led_in = LED_A; end
         endcase
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      if (cmd_pop && cmd.kind == CMD_EMIT) begin
         busy_in = 1'b1;
         len_in  = cmd.count;
         pos_in  = '0;
      end
      if (out_load) begin
         rsp_valid_in      = 1'b1;
         rsp_in.byte_valid = len_ff != '0;
         rsp_in.payload_byte = (len_ff != '0) ? store_ff[pos_ff] : 8'h00;
         rsp_in.last       = run_end;
         rsp_in.command_ok = (len_ff != '0) && ok_ff;
         rsp_in.led_index  = ((len_ff != '0) && ok_ff) ? led_ff : LED_A;
         pos_in            = pos_ff + 1'b1;
         if (run_end) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[store_idx] <= cmd.data;
      end
      ok_ff  <= ok_in;
      led_ff <= led_in;
      len_ff <= len_in;
      pos_ff <= pos_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> len_ff <= CNT_W'(PAYLOAD_DEPTH))
      else $error("run length beyond store depth");

   a_store_idx: assert property (@(posedge clock) disable iff (reset)
      store_we |-> cmd.count < CNT_W'(PAYLOAD_DEPTH))
      else $error("store index beyond depth");

   a_run_pos: assert property (@(posedge clock) disable iff (reset)
      busy_ff && len_ff != '0 |-> CNT_W'(pos_ff) < len_ff)
      else $error("run position past run length");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd_pop)
      else $error("command taken during a run");

endmodule

FILE: rtl/core/delimited_command_framer.sv
// Top level of the delimited command framer.
//
//   channel   direction  handshake          fields
//   req       in         req_push/req_full  req_rx_byte
//   rsp       out        rsp_pop/rsp_empty  rsp_payload_byte, rsp_byte_valid, rsp_last,
//                                           rsp_command_ok, rsp_led_index
//   csr       in         csr_we             csr_index, csr_wdata
//
// One request a cycle is taken while the command queue has room; a stored byte
// goes through the queue to the back end, a start byte or a dropped byte issues no
// command. An end byte leaves the queue as an emit command, then drains the frame
// one result a cycle from the payload store while rsp is not held; an empty frame
// still yields one result. Reset is synchronous; the payload store needs no clearing.
// A held rsp stalls the back end, the queue then fills and req_full rises.
module delimited_command_framer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last,
   output logic       rsp_command_ok,
   output logic [1:0] rsp_led_index,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);
   import dcf_pkg::*;

   logic    in_accept;
   logic    cmd_push;
   cmd_type cmd_in;
   logic    q_valid;
   logic    q_pop;
   cmd_type q_head;
   logic    rsp_valid;
   rsp_type rsp;

   assign in_accept = req_push && !req_full;

   dcf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_accept (in_accept),
      .in_byte   (req_rx_byte),
      .cmd_push  (cmd_push),
      .cmd       (cmd_in)
   );

   dcf_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd_in),
      .full     (req_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (q_head)
   );

   dcf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd       (q_head),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_empty        = !rsp_valid;
   assign rsp_payload_byte = rsp.payload_byte;
   assign rsp_byte_valid   = rsp.byte_valid;
   assign rsp_last         = rsp.last;
   assign rsp_command_ok   = rsp.command_ok;
   assign rsp_led_index    = rsp.led_index;

endmodule
